FILE: rtl/pva_pkg.sv
// Shared constants, types and pitch table for the polyphonic voice allocator.
package pva_pkg;

	localparam int VOICE_COUNT    = 8;
	localparam int HARMONIC_COUNT = 8;
	localparam int QUEUE_DEPTH    = 2;

	localparam int OP_W     = 2;
	localparam int CHAN_W   = 4;
	localparam int NOTE_W   = 7;
	localparam int VEL_W    = 7;
	localparam int VIDX_W   = 3;
	localparam int KIND_W   = 2;
	localparam int VOICE_W  = 3;
	localparam int MASK_W   = 8;
	localparam int HARM_W   = 3;
	localparam int INCR_W   = 32;

	localparam int TABLE_DEPTH = 256;
	localparam int TABLE_IDX_W = 8;
	localparam int TABLE_STEP  = 12;
	localparam int PITCH_RAW_W = 41;

	localparam int VOICE_SEL_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int HARM_CNT_W  = (HARMONIC_COUNT > 1) ? $clog2(HARMONIC_COUNT) : 1;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [OP_W-1:0]   OP_NOTE_ON    = 2'd0;
	localparam logic [OP_W-1:0]   OP_NOTE_OFF   = 2'd1;
	localparam logic [OP_W-1:0]   OP_VOICE_IDLE = 2'd2;
	localparam logic [CHAN_W-1:0] CHAN_ACTIVE   = 4'd0;

	localparam logic [KIND_W-1:0] KIND_HARMONIC = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_IGNORED  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_FREED    = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_ATTACK  = 2'd1,
		PH_RELEASE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CMD_NOTE_ON    = 2'd0,
		CMD_NOTE_OFF   = 2'd1,
		CMD_VOICE_FREE = 2'd2,
		CMD_IGNORE     = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [NOTE_W-1:0]   note;
		logic [VEL_W-1:0]    velocity;
		logic [VIDX_W-1:0]   voice_index;
	} cmd_t;

	// tuning words, full width; hardware keeps the low 32 bits
	localparam logic [PITCH_RAW_W-1:0] PITCH_TABLE [TABLE_DEPTH] = '{
		41'd877870, 41'd930071, 41'd985375, 41'd1043969, 41'd1106047, 41'd1171815,
		41'd1241495, 41'd1315318, 41'd1393531, 41'd1476395, 41'd1564186, 41'd1657197,
		41'd1755739, 41'd1860141, 41'd1970751, 41'd2087938, 41'd2212093, 41'd2343631,
		41'd2482991, 41'd2630637, 41'd2787063, 41'd2952790, 41'd3128372, 41'd3314395,
		41'd3511479, 41'd3720282, 41'd3941502, 41'd4175876, 41'd4424186, 41'd4687262,
		41'd4965981, 41'd5261274, 41'd5574125, 41'd5905580, 41'd6256744, 41'd6628789,
		41'd7022958, 41'd7440565, 41'd7883004, 41'd8351751, 41'd8848372, 41'd9374524,
		41'd9931962, 41'd10522547, 41'd11148251, 41'd11811160, 41'd12513488, 41'd13257579,
		41'd14045916, 41'd14881129, 41'd15766007, 41'd16703503, 41'd17696745, 41'd18749048,
		41'd19863924, 41'd21045095, 41'd22296501, 41'd23622320, 41'd25026976, 41'd26515158,
		41'd28091831, 41'd29762258, 41'd31532014, 41'd33407005, 41'd35393489, 41'd37498096,
		41'd39727849, 41'd42090189, 41'd44593002, 41'd47244640, 41'd50053953, 41'd53030316,
		41'd56183662, 41'd59524517, 41'd63064029, 41'd66814011, 41'd70786979, 41'd74996192,
		41'd79455697, 41'd84180379, 41'd89186005, 41'd94489281, 41'd100107906,
		41'd106060631, 41'd112367325, 41'd119049034, 41'd126128057, 41'd133628022,
		41'd141573958, 41'd149992383, 41'd158911395, 41'd168360758, 41'd178372009,
		41'd188978561, 41'd200215811, 41'd212121263, 41'd224734649, 41'd238098067,
		41'd252256115, 41'd267256044, 41'd283147915, 41'd299984767, 41'd317822789,
		41'd336721516, 41'd356744019, 41'd377957122, 41'd400431622, 41'd424242525,
		41'd449469299, 41'd476196134, 41'd504512230, 41'd534512088, 41'd566295831,
		41'd599969533, 41'd635645578, 41'd673443031, 41'd713488038, 41'd755914244,
		41'd800863244, 41'd848485051, 41'd898938597, 41'd952392268, 41'd1009024459,
		41'd1069024176, 41'd1132591661, 41'd1199939066, 41'd1271291156, 41'd1346886062,
		41'd1426976075, 41'd1511828488, 41'd1601726488, 41'd1696970102, 41'd1797877195,
		41'd1904784536, 41'd2018048919, 41'd2138048352, 41'd2265183323, 41'd2399878133,
		41'd2542582312, 41'd2693772124, 41'd2853952150, 41'd3023656976, 41'd3203452976,
		41'd3393940203, 41'd3595754390, 41'd3809569072, 41'd4036097837, 41'd4276096704,
		41'd4530366646, 41'd4799756265, 41'd5085164625, 41'd5387544249, 41'd5707904301,
		41'd6047313953, 41'd6406905953, 41'd6787880406, 41'd7191508779, 41'd7619138144,
		41'd8072195675, 41'd8552193408, 41'd9060733292, 41'd9599512530, 41'd10170329250,
		41'd10775088497, 41'd11415808601, 41'd12094627906, 41'd12813811906,
		41'd13575760812, 41'd14383017559, 41'd15238276289, 41'd16144391350,
		41'd17104386816, 41'd18121466583, 41'd19199025060, 41'd20340658499,
		41'd21550176995, 41'd22831617203, 41'd24189255811, 41'd25627623812,
		41'd27151521625, 41'd28766035117, 41'd30476552578, 41'd32288782699,
		41'd34208773632, 41'd36242933166, 41'd38398050121, 41'd40681316998,
		41'd43100353990, 41'd45663234406, 41'd48378511622, 41'd51255247624,
		41'd54303043250, 41'd57532070234, 41'd60953105155, 41'd64577565399,
		41'd68417547263, 41'd72485866332, 41'd76796100242, 41'd81362633997,
		41'd86200707979, 41'd91326468812, 41'd96757023244, 41'd102510495247,
		41'd108606086499, 41'd115064140469, 41'd121906210311, 41'd129155130797,
		41'd136835094527, 41'd144971732664, 41'd153592200483, 41'd162725267993,
		41'd172401415959, 41'd182652937624, 41'd193514046489, 41'd205020990495,
		41'd217212172998, 41'd230128280937, 41'd243812420621, 41'd258310261595,
		41'd273670189054, 41'd289943465329, 41'd307184400967, 41'd325450535987,
		41'd344802831918, 41'd365305875247, 41'd387028092977, 41'd410041980990,
		41'd434424345996, 41'd460256561874, 41'd487624841243, 41'd516620523189,
		41'd547340378108, 41'd579886930658, 41'd614368801933, 41'd650901071974,
		41'd689605663835, 41'd730611750495, 41'd774056185954, 41'd820083961979,
		41'd868848691993, 41'd920513123749, 41'd975249682485, 41'd1033241046379,
		41'd1094680756215, 41'd1159773861316, 41'd1228737603866, 41'd1301802143948,
		41'd1379211327671, 41'd1461223500989, 41'd1548112371909, 41'd1640167923958,
		41'd1737697383986, 41'd1841026247497, 41'd1950499364970, 41'd2066482092757,
		41'd2189361512431
	};

endpackage

FILE: rtl/pva_if.sv
// Event and result channel interfaces for the voice allocator.
interface pva_in_if;
	logic                          valid;
	logic                          ready;
	logic [pva_pkg::OP_W-1:0]      operation;
	logic [pva_pkg::CHAN_W-1:0]    channel;
	logic [pva_pkg::NOTE_W-1:0]    note;
	logic [pva_pkg::VEL_W-1:0]     velocity;
	logic [pva_pkg::VIDX_W-1:0]    voice_index;

	modport source (output valid, operation, channel, note, velocity, voice_index,
		input ready);
	modport sink (input valid, operation, channel, note, velocity, voice_index,
		output ready);
endinterface

interface pva_out_if;
	logic                          valid;
	logic                          ready;
	logic [pva_pkg::KIND_W-1:0]    kind;
	logic [pva_pkg::VOICE_W-1:0]   voice;
	logic [pva_pkg::MASK_W-1:0]    release_mask;
	logic [pva_pkg::HARM_W-1:0]    harmonic;
	logic [pva_pkg::INCR_W-1:0]    increment;
	logic                          last;

	modport source (output valid, kind, voice, release_mask, harmonic, increment, last,
		input ready);
	modport sink (input valid, kind, voice, release_mask, harmonic, increment, last,
		output ready);
endinterface

FILE: rtl/pva_front.sv
// Front end: accepts events and classifies them into commands.
module pva_front (
	pva_in_if.sink          in_ch,
	input  logic            q_full,
	output logic            push,
	output pva_pkg::cmd_t   push_cmd
);
	import pva_pkg::*;

	logic chan_ok;
	logic vidx_ok;

	assign chan_ok     = (in_ch.channel == CHAN_ACTIVE);
	assign vidx_ok     = (int'(in_ch.voice_index) < VOICE_COUNT);
	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;

	always_comb begin
		push_cmd.note        = in_ch.note;
		push_cmd.velocity    = in_ch.velocity;
		push_cmd.voice_index = in_ch.voice_index;
		if (in_ch.operation == OP_NOTE_ON && chan_ok) begin
			push_cmd.kind = CMD_NOTE_ON;
		end else if (in_ch.operation == OP_NOTE_OFF && chan_ok) begin
			push_cmd.kind = CMD_NOTE_OFF;
		end else if (in_ch.operation == OP_VOICE_IDLE && vidx_ok) begin
			push_cmd.kind = CMD_VOICE_FREE;
		end else begin
			push_cmd.kind = CMD_IGNORE;
		end
	end

endmodule

FILE: rtl/pva_cmd_queue.sv
// Short command queue between front end and voice engine.
module pva_cmd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pva_pkg::cmd_t   push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            pop_valid,
	output pva_pkg::cmd_t   pop_cmd
);
	import pva_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd   = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/pva_back.sv
// Voice engine: voice state, allocation, release and harmonic word stream.
module pva_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  pva_pkg::cmd_t   q_cmd,
	output logic            q_pop,
	pva_out_if.source       out_ch
);
	import pva_pkg::*;

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_HARM = 2'b10
	} bk_state_t;

	bk_state_t                state_q;
	logic [NOTE_W-1:0]        voice_note_q  [VOICE_COUNT];
	logic [VEL_W-1:0]         voice_vel_q   [VOICE_COUNT];
	phase_t                   voice_phase_q [VOICE_COUNT];

	logic [VOICE_SEL_W-1:0]   pick_q;
	logic [NOTE_W-1:0]        note_q;
	logic [HARM_CNT_W-1:0]    harm_q;

	logic                     out_valid_q;
	logic [KIND_W-1:0]        out_kind_q;
	logic [VOICE_W-1:0]       out_voice_q;
	logic [MASK_W-1:0]        out_mask_q;
	logic [HARM_W-1:0]        out_harm_q;
	logic [INCR_W-1:0]        out_incr_q;
	logic                     out_last_q;

	logic                     out_free;
	logic                     harm_emit;
	logic                     harm_final;
	logic                     load_out;
	logic [KIND_W-1:0]        kind_d;
	logic [VOICE_W-1:0]       voice_d;
	logic [MASK_W-1:0]        mask_d;
	logic [TABLE_IDX_W-1:0]   tbl_idx;
	logic [PITCH_RAW_W-1:0]   tbl_word;

	logic                     found;
	logic                     idle_seen;
	logic                     rel_seen;
	logic [VOICE_SEL_W-1:0]   match_at;
	logic [VOICE_SEL_W-1:0]   idle_at;
	logic [VOICE_SEL_W-1:0]   rel_at;
	logic [VOICE_SEL_W-1:0]   pick;
	logic [VOICE_COUNT-1:0]   off_hits;
	logic [VOICE_SEL_W-1:0]   free_sel;

	assign out_free   = !out_valid_q || out_ch.ready;
	assign q_pop      = (state_q == BK_IDLE) && q_valid && out_free;
	assign harm_emit  = (state_q == BK_HARM) && out_free;
	assign harm_final = (harm_q == HARM_CNT_W'(HARMONIC_COUNT - 1));
	assign free_sel   = VOICE_SEL_W'(q_cmd.voice_index);

	assign tbl_idx  = TABLE_IDX_W'(int'(note_q) + TABLE_STEP * int'(harm_q));
	assign tbl_word = PITCH_TABLE[tbl_idx];

	// voice choice: same note first, else last idle, else last releasing, else voice 0
	always_comb begin
		found     = 1'b0;
		idle_seen = 1'b0;
		rel_seen  = 1'b0;
		match_at  = '0;
		idle_at   = '0;
		rel_at    = '0;
		for (int v = 0; v < VOICE_COUNT; v++) begin
			if (!found) begin
				if (voice_note_q[v] == q_cmd.note) begin
					found    = 1'b1;
					match_at = VOICE_SEL_W'(v);
				end else if (voice_phase_q[v] == PH_RELEASE) begin
					rel_seen = 1'b1;
					rel_at   = VOICE_SEL_W'(v);
				end else if (voice_phase_q[v] == PH_IDLE) begin
					idle_seen = 1'b1;
					idle_at   = VOICE_SEL_W'(v);
				end
			end
		end
		if (found) begin
			pick = match_at;
		end else if (idle_seen) begin
			pick = idle_at;
		end else if (rel_seen) begin
			pick = rel_at;
		end else begin
			pick = '0;
		end
	end

	always_comb begin
		for (int v = 0; v < VOICE_COUNT; v++) begin
			off_hits[v] = (voice_note_q[v] == q_cmd.note);
		end
	end

	always_comb begin
		load_out = 1'b0;
		kind_d   = KIND_IGNORED;
		voice_d  = '0;
		mask_d   = '0;
		if (harm_emit) begin
			load_out = 1'b1;
			kind_d   = KIND_HARMONIC;
			voice_d  = VOICE_W'(pick_q);
		end else if (q_pop) begin
			case (q_cmd.kind)
				CMD_NOTE_OFF: begin
					load_out = 1'b1;
					kind_d   = KIND_RELEASE;
					mask_d   = MASK_W'(off_hits);
				end
				CMD_VOICE_FREE: begin
					load_out = 1'b1;
					kind_d   = KIND_FREED;
					voice_d  = VOICE_W'(q_cmd.voice_index);
				end
				CMD_IGNORE: begin
					load_out = 1'b1;
				end
				default: begin
					load_out = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
			harm_q      <= '0;
			for (int v = 0; v < VOICE_COUNT; v++) begin
				voice_note_q[v]  <= '0;
				voice_vel_q[v]   <= '0;
				voice_phase_q[v] <= PH_IDLE;
			end
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (q_pop) begin
						case (q_cmd.kind)
							CMD_NOTE_ON: begin
								voice_note_q[pick]  <= q_cmd.note;
								voice_vel_q[pick]   <= q_cmd.velocity;
								voice_phase_q[pick] <= PH_ATTACK;
								harm_q              <= '0;
								state_q             <= BK_HARM;
							end
							CMD_NOTE_OFF: begin
								for (int v = 0; v < VOICE_COUNT; v++) begin
									if (off_hits[v]) begin
										voice_vel_q[v]   <= q_cmd.velocity;
										voice_phase_q[v] <= PH_RELEASE;
									end
								end
							end
							CMD_VOICE_FREE: begin
								voice_phase_q[free_sel] <= PH_IDLE;
							end
							default: begin
							end
						endcase
					end
				end
				BK_HARM: begin
					if (harm_emit) begin
						harm_q <= harm_q + 1'b1;
						if (harm_final) begin
							state_q <= BK_IDLE;
						end
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.kind == CMD_NOTE_ON) begin
			pick_q <= pick;
			note_q <= q_cmd.note;
		end
		if (load_out) begin
			out_kind_q  <= kind_d;
			out_voice_q <= voice_d;
			out_mask_q  <= mask_d;
			out_harm_q  <= harm_emit ? HARM_W'(harm_q) : '0;
			out_incr_q  <= harm_emit ? tbl_word[INCR_W-1:0] : '0;
			out_last_q  <= harm_emit ? harm_final : 1'b1;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.kind         = out_kind_q;
	assign out_ch.voice        = out_voice_q;
	assign out_ch.release_mask = out_mask_q;
	assign out_ch.harmonic     = out_harm_q;
	assign out_ch.increment    = out_incr_q;
	assign out_ch.last         = out_last_q;

endmodule

FILE: rtl/poly_voice_allocator_unit.sv
// Top level of the polyphonic voice allocator.
// Events enter a classifier that transfers them into a two-entry command queue, so the
// input keeps moving while the voice engine is busy. The engine takes one command per cycle
// from the queue when it is idle and its output register is free. A note-on picks and
// claims a voice, then emits one phase increment per harmonic from the constant pitch
// table, one per cycle while the output register is free (eight harmonics). Note-off,
// voice-free and ignored events each yield one result. The output register sets the pace:
// a stalled consumer holds the engine, and the queue absorbs up to two further events.
module poly_voice_allocator_unit (
	input  logic       clk,
	input  logic       arst_n,
	pva_in_if.sink     in_ch,
	pva_out_if.source  out_ch
);
	import pva_pkg::*;

	logic  q_full;
	logic  push;
	cmd_t  push_cmd;
	logic  q_pop;
	logic  q_valid;
	cmd_t  q_cmd;

	pva_front u_front (
		.in_ch    (in_ch),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	pva_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_cmd   (q_cmd)
	);

	pva_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

FILE: tb/poly_voice_allocator_unit_test.sv
// Self-checking testbench for poly_voice_allocator_unit: predicted results vs DUT output.
`timescale 1ns / 1ps

module poly_voice_allocator_unit_test;
	import pva_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_EVENTS = 380;
	localparam int NOTE_POOL     = 12;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 30;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [CHAN_W-1:0] chan;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  vel;
		logic [VIDX_W-1:0] vidx;
		int                gap_after;
		bit                drain;
	} midi_event_t;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic [VOICE_W-1:0] voice;
		logic [MASK_W-1:0]  mask;
		logic [HARM_W-1:0]  harmonic;
		logic [INCR_W-1:0]  increment;
		logic               last;
	} alloc_result_t;

	logic clk;
	logic arst_n;

	pva_in_if  in_ch ();
	pva_out_if out_ch ();

	poly_voice_allocator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	midi_event_t   pending_events [$];
	alloc_result_t results_due [$];
	midi_event_t   on_bus;

	logic [NOTE_W-1:0] held_note  [VOICE_COUNT];
	logic [VEL_W-1:0]  held_vel   [VOICE_COUNT];
	phase_t            held_phase [VOICE_COUNT];

	int error_count;
	int cycle_count;
	int events_total;
	int events_taken;
	int idle_left;
	int stall_left;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic midi_event_t make_event(logic [OP_W-1:0] op, logic [CHAN_W-1:0] chan,
		logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel, logic [VIDX_W-1:0] vidx);
		midi_event_t ev;
		ev.op        = op;
		ev.chan      = chan;
		ev.note      = note;
		ev.vel       = vel;
		ev.vidx      = vidx;
		ev.gap_after = draw_gap();
		ev.drain     = 1'b0;
		return ev;
	endfunction

	function automatic alloc_result_t single_result(logic [KIND_W-1:0] kind,
		logic [VOICE_W-1:0] voice, logic [MASK_W-1:0] mask);
		alloc_result_t r;
		r.kind      = kind;
		r.voice     = voice;
		r.mask      = mask;
		r.harmonic  = '0;
		r.increment = '0;
		r.last      = 1'b1;
		return r;
	endfunction

	// voice allocation and the results each event produces
	function automatic void apply_midi_event(midi_event_t ev);
		int pick;
		int idle_at;
		int rel_at;
		logic [MASK_W-1:0] mask;
		logic [TABLE_IDX_W-1:0] tidx;
		alloc_result_t r;
		if (ev.op == OP_NOTE_ON && ev.chan == CHAN_ACTIVE) begin
			pick    = -1;
			idle_at = -1;
			rel_at  = -1;
			for (int v = 0; v < VOICE_COUNT; v++) begin
				if (pick < 0) begin
					if (held_note[v] == ev.note)
						pick = v;
					else if (held_phase[v] == PH_RELEASE)
						rel_at = v;
					else if (held_phase[v] == PH_IDLE)
						idle_at = v;
				end
			end
			if (pick < 0)
				pick = (idle_at >= 0) ? idle_at : ((rel_at >= 0) ? rel_at : 0);
			held_note[pick]  = ev.note;
			held_vel[pick]   = ev.vel;
			held_phase[pick] = PH_ATTACK;
			for (int h = 0; h < HARMONIC_COUNT; h++) begin
				tidx        = TABLE_IDX_W'(ev.note + TABLE_STEP * h);
				r.kind      = KIND_HARMONIC;
				r.voice     = VOICE_W'(pick);
				r.mask      = '0;
				r.harmonic  = HARM_W'(h);
				r.increment = PITCH_TABLE[tidx][INCR_W-1:0];
				r.last      = (h == HARMONIC_COUNT - 1);
				results_due.push_back(r);
			end
		end else if (ev.op == OP_NOTE_OFF && ev.chan == CHAN_ACTIVE) begin
			mask = '0;
			for (int v = 0; v < VOICE_COUNT; v++) begin
				if (held_note[v] == ev.note) begin
					held_vel[v]   = ev.vel;
					held_phase[v] = PH_RELEASE;
					mask[v]       = 1'b1;
				end
			end
			results_due.push_back(single_result(KIND_RELEASE, '0, mask));
		end else if (ev.op == OP_VOICE_IDLE && ev.vidx < VOICE_COUNT) begin
			held_phase[ev.vidx] = PH_IDLE;
			results_due.push_back(single_result(KIND_FREED, ev.vidx, '0));
		end else begin
			results_due.push_back(single_result(KIND_IGNORED, '0, '0));
		end
	endfunction

	task automatic flag_mismatch(string msg);
		error_count++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	always @(posedge clk) begin
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// event driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid       <= 1'b0;
			in_ch.operation   <= '0;
			in_ch.channel     <= '0;
			in_ch.note        <= '0;
			in_ch.velocity    <= '0;
			in_ch.voice_index <= '0;
			idle_left = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				apply_midi_event(on_bus);
				events_taken++;
				idle_left = on_bus.gap_after;
			end
			if (!(in_ch.valid && !in_ch.ready)) begin
				if (idle_left > 0) begin
					idle_left--;
					in_ch.valid <= 1'b0;
				end else if (pending_events.size() != 0 &&
					(!pending_events[0].drain || results_due.size() == 0)) begin
					on_bus = pending_events.pop_front();
					in_ch.valid       <= 1'b1;
					in_ch.operation   <= on_bus.op;
					in_ch.channel     <= on_bus.chan;
					in_ch.note        <= on_bus.note;
					in_ch.velocity    <= on_bus.vel;
					in_ch.voice_index <= on_bus.vidx;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and backpressure
	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (results_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected transfer kind=%0d voice=%0d mask=%h",
						out_ch.kind, out_ch.voice, out_ch.release_mask));
				end else begin
					want = results_due.pop_front();
					if (out_ch.kind !== want.kind || out_ch.voice !== want.voice ||
						out_ch.release_mask !== want.mask || out_ch.harmonic !== want.harmonic ||
						out_ch.increment !== want.increment || out_ch.last !== want.last)
						flag_mismatch($sformatf(
							"got k%0d v%0d m%h h%0d i%h l%0d, want k%0d v%0d m%h h%0d i%h l%0d",
							out_ch.kind, out_ch.voice, out_ch.release_mask, out_ch.harmonic,
							out_ch.increment, out_ch.last, want.kind, want.voice, want.mask,
							want.harmonic, want.increment, want.last));
				end
			end
			if (stall_left == 0 && (cycle_count / 600) % 3 != 0 && $urandom_range(0, 9) < 3)
				stall_left = draw_gap();
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		midi_event_t ev;
		logic [NOTE_W-1:0] note_pool [NOTE_POOL];
		logic [NOTE_W-1:0] nt;
		int sel;

		clk               = 1'b0;
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.operation   = '0;
		in_ch.channel     = '0;
		in_ch.note        = '0;
		in_ch.velocity    = '0;
		in_ch.voice_index = '0;
		out_ch.ready      = 1'b0;
		error_count       = 0;
		cycle_count       = 0;
		events_total      = 0;
		events_taken      = 0;
		for (int v = 0; v < VOICE_COUNT; v++) begin
			held_note[v]  = '0;
			held_vel[v]   = '0;
			held_phase[v] = PH_IDLE;
		end

		// directed: reset notes match, idle/release/fallback choice, ignored events
		pending_events.push_back(make_event(OP_NOTE_ON, CHAN_ACTIVE, 7'd0, 7'd127, 3'd0));
		pending_events.push_back(make_event(OP_NOTE_ON, CHAN_ACTIVE, 7'd127, 7'd0, 3'd7));
		pending_events.push_back(make_event(OP_NOTE_ON, 4'd15, 7'd60, 7'd100, 3'd0));
		pending_events.push_back(make_event(OP_NOTE_OFF, 4'd9, 7'd127, 7'd5, 3'd0));
		pending_events.push_back(make_event(OP_UNUSED, CHAN_ACTIVE, 7'd127, 7'd127, 3'd7));
		pending_events.push_back(make_event(OP_NOTE_OFF, CHAN_ACTIVE, 7'd127, 7'd64, 3'd0));
		pending_events.push_back(make_event(OP_NOTE_OFF, CHAN_ACTIVE, 7'd50, 7'd3, 3'd0));
		pending_events.push_back(make_event(OP_NOTE_OFF, CHAN_ACTIVE, 7'd0, 7'd1, 3'd0));
		for (int n = 10; n < 18; n++)
			pending_events.push_back(make_event(OP_NOTE_ON, CHAN_ACTIVE, NOTE_W'(n),
				VEL_W'(n * 7), 3'd0));
		pending_events.push_back(make_event(OP_NOTE_ON, CHAN_ACTIVE, 7'd40, 7'd90, 3'd0));
		pending_events.push_back(make_event(OP_VOICE_IDLE, 4'd7, 7'd85, 7'd42, 3'd3));
		pending_events.push_back(make_event(OP_NOTE_ON, CHAN_ACTIVE, 7'd41, 7'd33, 3'd0));
		pending_events.push_back(make_event(OP_VOICE_IDLE, CHAN_ACTIVE, 7'd0, 7'd0, 3'd0));
		pending_events.push_back(make_event(OP_NOTE_ON, CHAN_ACTIVE, 7'd13, 7'd77, 3'd0));
		pending_events.push_back(make_event(OP_NOTE_ON, CHAN_ACTIVE, 7'd40, 7'd11, 3'd0));
		pending_events.push_back(make_event(OP_NOTE_OFF, CHAN_ACTIVE, 7'd41, 7'd1, 3'd0));
		pending_events.push_back(make_event(OP_NOTE_ON, CHAN_ACTIVE, 7'd90, 7'd85, 3'd5));

		// random: mostly note on/off over a small note pool so voices collide
		for (int i = 0; i < RANDOM_EVENTS; i++) begin
			if (i % 60 == 0)
				for (int k = 0; k < NOTE_POOL; k++)
					note_pool[k] = NOTE_W'($urandom_range(0, 127));
			nt  = note_pool[$urandom_range(0, NOTE_POOL - 1)];
			sel = $urandom_range(0, 99);
			if (sel < 38)
				ev = make_event(OP_NOTE_ON, CHAN_ACTIVE, nt, VEL_W'($urandom_range(0, 127)),
					VIDX_W'($urandom_range(0, 7)));
			else if (sel < 63)
				ev = make_event(OP_NOTE_OFF, CHAN_ACTIVE, nt, VEL_W'($urandom_range(0, 127)),
					VIDX_W'($urandom_range(0, 7)));
			else if (sel < 80)
				ev = make_event(OP_VOICE_IDLE, CHAN_W'($urandom_range(0, 15)),
					NOTE_W'($urandom_range(0, 127)), VEL_W'($urandom_range(0, 127)),
					VIDX_W'($urandom_range(0, 7)));
			else if (sel < 88)
				ev = make_event(OP_W'($urandom_range(0, 1)), CHAN_W'($urandom_range(1, 15)),
					nt, VEL_W'($urandom_range(0, 127)), VIDX_W'($urandom_range(0, 7)));
			else if (sel < 92)
				ev = make_event(OP_UNUSED, CHAN_W'($urandom_range(0, 15)),
					NOTE_W'($urandom_range(0, 127)), VEL_W'($urandom_range(0, 127)),
					VIDX_W'($urandom_range(0, 7)));
			else
				ev = make_event(OP_W'($urandom_range(0, 1)), CHAN_ACTIVE,
					NOTE_W'($urandom_range(0, 127)), VEL_W'($urandom_range(0, 127)),
					VIDX_W'($urandom_range(0, 7)));
			if ((i / 40) % 4 == 1)
				ev.gap_after = 0;
			if (i == 0 || i == 150 || i == 300)
				ev.drain = 1'b1;
			pending_events.push_back(ev);
		end
		events_total = pending_events.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (events_taken != events_total)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
